// File: hdl/ctg_pkg.sv
// Shared types, codes and helpers for the colored text glyph layout block.
`timescale 1ns / 1ps
`default_nettype none

package ctg_pkg;

  localparam int GLYPH_ENTRIES_DEF = 128;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 8;

  // Character codes with a fixed meaning
  localparam logic [7:0] CODE_NUL      = 8'd0;
  localparam logic [7:0] CODE_NEWLINE  = 8'd10;
  localparam logic [7:0] CODE_SPACE    = 8'd32;
  localparam logic [7:0] CODE_QUESTION = 8'd63;

  // Offset of the last of the nine color codes from the base code
  localparam logic [7:0] COLOR_SPAN = 8'd8;

  localparam logic [7:0] SPACE_WIDTH_RST     = 8'd8;
  localparam logic [7:0] LINE_HEIGHT_RST     = 8'd16;
  localparam logic [6:0] FIRST_PRINTABLE_RST = 7'd32;
  localparam logic [6:0] LAST_PRINTABLE_RST  = 7'd126;
  localparam logic [4:0] COLOR_CODE_BASE_RST = 5'd1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_CHAR  = 2'd2
  } ctg_op_e;

  typedef enum logic {
    KIND_GLYPH = 1'b0,
    KIND_END   = 1'b1
  } ctg_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPACE_WIDTH     = 3'd0,
    CFG_LINE_HEIGHT     = 3'd1,
    CFG_FIRST_PRINTABLE = 3'd2,
    CFG_LAST_PRINTABLE  = 3'd3,
    CFG_COLOR_CODE_BASE = 3'd4
  } ctg_cfg_idx_e;

  typedef struct packed {
    logic [7:0] space_width;
    logic [7:0] line_height;
    logic [6:0] first_printable;
    logic [6:0] last_printable;
    logic [4:0] color_code_base;
  } ctg_cfg_t;

  typedef struct packed {
    logic [11:0] left;
    logic [11:0] top;
    logic [11:0] right;
    logic [11:0] bottom;
  } ctg_rect_t;

  typedef struct packed {
    ctg_kind_e   kind;
    logic [15:0] dest_left;
    logic [15:0] dest_top;
    logic [15:0] dest_right;
    logic [15:0] dest_bottom;
    ctg_rect_t   src;
    logic [3:0]  color_index;
  } ctg_result_t;

  // Clamp an 18-bit signed sum to the 16-bit signed range
  function automatic logic [15:0] sat16(input logic [17:0] v);
    logic [15:0] r;
    if (!v[17] && (v[16:15] != 2'b00)) begin
      r = 16'h7fff;
    end else if (v[17] && (v[16:15] != 2'b11)) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/colored_text_glyph_layout.sv
// Top level of the colored bitmap-font text layout block.
//
// Input channel (in_valid_i / in_ready_o) takes one item per cycle: a glyph
// table load, a string start or a character. Output channel (out_valid_o /
// out_ready_i) returns a glyph sprite or an end-of-string item, at most one
// per input item. Configuration writes go through cfg_valid_i / cfg_ready_o
// with a register index and data; cfg_ready_o is always high.
//
// An accepted item is registered in the item stage together with its glyph
// memory read; when the item stage advances, it updates the pen and loads
// the output register. Throughput is one item per cycle while the item
// stage is not held, set by the pen update against the registered glyph
// read. The output register decouples the sides, so a new item is taken
// while a result waits; when the receiver stalls with a result pending the
// item stage holds and in_ready_o drops only if that item also has a result.
//
// Reset clears the pen, line start and color to zero and the configuration
// to its defaults. The glyph memory is not cleared; load an entry before
// drawing with it.
`timescale 1ns / 1ps
`default_nettype none

module colored_text_glyph_layout #(
  parameter int GlyphEntries = ctg_pkg::GLYPH_ENTRIES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     op_i,
  input  wire logic [7:0]                     char_code_i,
  input  wire logic [11:0]                    glyph_left_i,
  input  wire logic [11:0]                    glyph_top_i,
  input  wire logic [11:0]                    glyph_right_i,
  input  wire logic [11:0]                    glyph_bottom_i,
  input  wire logic [15:0]                    origin_x_i,
  input  wire logic [15:0]                    origin_y_i,

  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                kind_o,
  output logic [15:0]                         dest_left_o,
  output logic [15:0]                         dest_top_o,
  output logic [15:0]                         dest_right_o,
  output logic [15:0]                         dest_bottom_o,
  output logic [11:0]                         src_left_o,
  output logic [11:0]                         src_top_o,
  output logic [11:0]                         src_right_o,
  output logic [11:0]                         src_bottom_o,
  output logic [3:0]                          color_index_o,

  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ctg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ctg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AddrW = $clog2(GlyphEntries);
  localparam logic [8:0] EntriesW = 9'(GlyphEntries);

  ctg_pkg::ctg_cfg_t    cfg;
  ctg_pkg::ctg_rect_t   load_rect;
  ctg_pkg::ctg_rect_t   ram_rdata;
  ctg_pkg::ctg_rect_t   glyph;
  ctg_pkg::ctg_result_t result;
  ctg_pkg::ctg_result_t out_q;

  logic        in_fire;
  logic        s1_adv;
  logic        has_result;
  logic [7:0]  glyph_code;
  logic        glyph_hit;
  logic        load_we;

  logic        s1_valid_q;
  logic [1:0]  s1_op_q;
  logic [7:0]  s1_code_q;
  logic [15:0] s1_origin_x_q;
  logic [15:0] s1_origin_y_q;
  logic        s1_hit_q;
  logic        out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  ctg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign in_fire = in_valid_i && in_ready_o;

  // Codes outside the printable range draw the question mark glyph
  always_comb begin
    if ((char_code_i < {1'b0, cfg.first_printable}) ||
        (char_code_i > {1'b0, cfg.last_printable})) begin
      glyph_code = ctg_pkg::CODE_QUESTION;
    end else begin
      glyph_code = char_code_i;
    end
  end

  assign glyph_hit = {1'b0, glyph_code} < EntriesW;
  assign load_we   = in_fire && (op_i == ctg_pkg::OP_LOAD) &&
                     ({1'b0, char_code_i} < EntriesW);

  assign load_rect.left   = glyph_left_i;
  assign load_rect.top    = glyph_top_i;
  assign load_rect.right  = glyph_right_i;
  assign load_rect.bottom = glyph_bottom_i;

  ctg_glyph_ram #(
    .GlyphEntries (GlyphEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (char_code_i[AddrW-1:0]),
    .wdata_i (load_rect),
    .re_i    (in_fire),
    .raddr_i (glyph_code[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Glyph indexes past the table read as an empty rectangle
  assign glyph = s1_hit_q ? ram_rdata : '0;

  ctg_pen u_pen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s1_valid_q),
    .advance_i    (s1_adv),
    .op_i         (s1_op_q),
    .code_i       (s1_code_q),
    .origin_x_i   (s1_origin_x_q),
    .origin_y_i   (s1_origin_y_q),
    .glyph_i      (glyph),
    .cfg_i        (cfg),
    .has_result_o (has_result),
    .result_o     (result)
  );

  // Advance the item stage unless its result would overwrite a pending one
  assign s1_adv     = s1_valid_q && (!has_result || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q       <= op_i;
      s1_code_q     <= char_code_i;
      s1_origin_x_q <= origin_x_i;
      s1_origin_y_q <= origin_y_i;
      s1_hit_q      <= glyph_hit;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && has_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && has_result) begin
      out_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_q.kind;
  assign dest_left_o   = out_q.dest_left;
  assign dest_top_o    = out_q.dest_top;
  assign dest_right_o  = out_q.dest_right;
  assign dest_bottom_o = out_q.dest_bottom;
  assign src_left_o    = out_q.src.left;
  assign src_top_o     = out_q.src.top;
  assign src_right_o   = out_q.src.right;
  assign src_bottom_o  = out_q.src.bottom;
  assign color_index_o = out_q.color_index;

endmodule

`default_nettype wire

// File: hdl/ctg_cfg_regs.sv
// Configuration register file of the text layout block.
`timescale 1ns / 1ps
`default_nettype none

module ctg_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ctg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ctg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ctg_pkg::ctg_cfg_t                  cfg_o
);

  ctg_pkg::ctg_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ctg_pkg::ctg_cfg_idx_e'(cfg_index_i))
        ctg_pkg::CFG_SPACE_WIDTH:     cfg_d.space_width     = cfg_data_i;
        ctg_pkg::CFG_LINE_HEIGHT:     cfg_d.line_height     = cfg_data_i;
        ctg_pkg::CFG_FIRST_PRINTABLE: cfg_d.first_printable = cfg_data_i[6:0];
        ctg_pkg::CFG_LAST_PRINTABLE:  cfg_d.last_printable  = cfg_data_i[6:0];
        ctg_pkg::CFG_COLOR_CODE_BASE: cfg_d.color_code_base = cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.space_width     <= ctg_pkg::SPACE_WIDTH_RST;
      cfg_q.line_height     <= ctg_pkg::LINE_HEIGHT_RST;
      cfg_q.first_printable <= ctg_pkg::FIRST_PRINTABLE_RST;
      cfg_q.last_printable  <= ctg_pkg::LAST_PRINTABLE_RST;
      cfg_q.color_code_base <= ctg_pkg::COLOR_CODE_BASE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hdl/ctg_glyph_ram.sv
// Glyph source rectangle memory, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ctg_glyph_ram #(
  parameter int GlyphEntries = ctg_pkg::GLYPH_ENTRIES_DEF,
  localparam int AddrW = $clog2(GlyphEntries)
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrW-1:0]    waddr_i,
  input  wire ctg_pkg::ctg_rect_t  wdata_i,
  input  wire logic                re_i,
  input  wire logic [AddrW-1:0]    raddr_i,
  output ctg_pkg::ctg_rect_t       rdata_o
);

  ctg_pkg::ctg_rect_t mem [GlyphEntries];
  ctg_pkg::ctg_rect_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/ctg_pen.sv
// Pen and color state with the per-item layout decision and result build.
`timescale 1ns / 1ps
`default_nettype none

module ctg_pen (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic               advance_i,
  input  wire logic [1:0]         op_i,
  input  wire logic [7:0]         code_i,
  input  wire logic [15:0]        origin_x_i,
  input  wire logic [15:0]        origin_y_i,
  input  wire ctg_pkg::ctg_rect_t glyph_i,
  input  wire ctg_pkg::ctg_cfg_t  cfg_i,
  output logic                    has_result_o,
  output ctg_pkg::ctg_result_t    result_o
);

  logic [15:0] pen_x_q, pen_x_d;
  logic [15:0] pen_y_q, pen_y_d;
  logic [15:0] line_x_q, line_x_d;
  logic [3:0]  color_q, color_d;

  logic [7:0]  color_lo;
  logic [7:0]  color_hi;
  logic [7:0]  color_off;
  logic        is_color;
  logic [12:0] width;
  logic [12:0] height;
  logic [17:0] pen_x_ext;
  logic [17:0] pen_y_ext;
  logic [17:0] right_sum;
  logic [17:0] bottom_sum;
  logic [17:0] next_x_sum;
  logic [17:0] space_sum;
  logic [17:0] line_sum;

  assign color_lo  = {3'b000, cfg_i.color_code_base};
  assign color_hi  = color_lo + ctg_pkg::COLOR_SPAN;
  assign color_off = code_i - color_lo;
  assign is_color  = (code_i >= color_lo) && (code_i <= color_hi);

  // Width and height may be negative for an inverted rectangle
  assign width  = {1'b0, glyph_i.right} - {1'b0, glyph_i.left};
  assign height = {1'b0, glyph_i.bottom} - {1'b0, glyph_i.top};

  assign pen_x_ext  = {{2{pen_x_q[15]}}, pen_x_q};
  assign pen_y_ext  = {{2{pen_y_q[15]}}, pen_y_q};
  assign right_sum  = pen_x_ext + {{5{width[12]}}, width};
  assign bottom_sum = pen_y_ext + {{5{height[12]}}, height};
  assign next_x_sum = right_sum + 18'd1;
  assign space_sum  = pen_x_ext + {10'd0, cfg_i.space_width};
  assign line_sum   = pen_y_ext + {10'd0, cfg_i.line_height};

  always_comb begin
    pen_x_d      = pen_x_q;
    pen_y_d      = pen_y_q;
    line_x_d     = line_x_q;
    color_d      = color_q;
    has_result_o = 1'b0;

    result_o.kind        = ctg_pkg::KIND_GLYPH;
    result_o.dest_left   = pen_x_q;
    result_o.dest_top    = pen_y_q;
    result_o.dest_right  = ctg_pkg::sat16(right_sum);
    result_o.dest_bottom = ctg_pkg::sat16(bottom_sum);
    result_o.src         = glyph_i;
    result_o.color_index = color_q;

    if (valid_i) begin
      case (op_i)
        ctg_pkg::OP_START: begin
          pen_x_d  = origin_x_i;
          pen_y_d  = origin_y_i;
          line_x_d = origin_x_i;
          color_d  = '0;
        end
        ctg_pkg::OP_CHAR: begin
          if (code_i == ctg_pkg::CODE_SPACE) begin
            pen_x_d = ctg_pkg::sat16(space_sum);
          end else if (code_i == ctg_pkg::CODE_NEWLINE) begin
            pen_x_d = line_x_q;
            pen_y_d = ctg_pkg::sat16(line_sum);
          end else if (is_color) begin
            color_d = color_off[3:0];
          end else if (code_i == ctg_pkg::CODE_NUL) begin
            has_result_o         = 1'b1;
            result_o.kind        = ctg_pkg::KIND_END;
            result_o.dest_right  = pen_x_q;
            result_o.dest_bottom = pen_y_q;
            result_o.src         = '0;
          end else begin
            has_result_o = 1'b1;
            pen_x_d      = ctg_pkg::sat16(next_x_sum);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q  <= '0;
      pen_y_q  <= '0;
      line_x_q <= '0;
      color_q  <= '0;
    end else if (advance_i) begin
      pen_x_q  <= pen_x_d;
      pen_y_q  <= pen_y_d;
      line_x_q <= line_x_d;
      color_q  <= color_d;
    end
  end

endmodule

`default_nettype wire
